/* rtl/efla_pkg.sv */
`default_nettype none
package efla_pkg;

   localparam int unsigned DEF_HEAP_BYTES  = 65536;
   localparam int unsigned DEF_CHUNK_BYTES = 256;

   localparam int KIND_W   = 2;
   localparam int SIZE_W   = 16;
   localparam int ADDR_W   = 16;
   localparam int STATUS_W = 2;
   localparam int WORD_W   = 32;

   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_INIT  = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK   = 2'd0,
      STATUS_NULL = 2'd1,
      STATUS_OOM  = 2'd2
   } status_type;

   localparam logic [WORD_W-1:0] SIZE_MASK     = 32'hFFFF_FFF8;
   localparam logic [WORD_W-1:0] ALLOC_BIT     = 32'h0000_0001;
   localparam logic [WORD_W-1:0] MIN_BLOCK     = 32'd24;
   localparam logic [WORD_W-1:0] PROLOGUE_WORD = 32'd9;
   localparam logic [WORD_W-1:0] EPILOGUE_WORD = 32'd1;
   localparam logic [WORD_W-1:0] FIRST_BP      = 32'd16;

   typedef enum logic [6:0] {
      S_IDLE, S_CLEAR, S_INIT0, S_INIT1, S_INIT2, S_INIT3,
      S_FF1, S_FF2, S_FF3, S_AGROW, S_AGROW_RET,
      S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6, S_T7, S_TN1, S_TN2, S_AEND,
      S_Q0, S_Q1, S_Q2, S_Q3, S_Q4, S_QEND,
      S_G0, S_G1, S_G2, S_G3, S_G4, S_G5,
      S_M0, S_M1, S_M2, S_M3, S_M4, S_M5, S_M6,
      S_B1, S_B2, S_B3,
      S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_C8, S_C9,
      S_D1, S_D2, S_D3, S_D4, S_D5, S_D6, S_D7, S_D8, S_D9, S_D10,
      S_D11, S_D12, S_D13, S_D14,
      S_LA0, S_LA1, S_LA2,
      S_LR0, S_LR1, S_LR2, S_LR3, S_LR4, S_LR5, S_LR6, S_LR7,
      S_DONE
   } state_type;

endpackage
`default_nettype wire

/* rtl/efla_ifs.sv */
`default_nettype none
interface efla_req_if import efla_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [SIZE_W-1:0] req_size;
   logic [ADDR_W-1:0] block_addr;
   modport source (output valid, kind, req_size, block_addr, input ready);
   modport sink   (input valid, kind, req_size, block_addr, output ready);
endinterface

interface efla_rsp_if import efla_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   result_addr;
   modport source (output valid, status, result_addr, input ready);
   modport sink   (input valid, status, result_addr, output ready);
endinterface
`default_nettype wire

/* rtl/explicit_free_list_allocator_core.sv */
// Channel  | Dir | Payload                     | Transaction
// req_ch   | in  | kind, req_size, block_addr  | valid & ready
// rsp_ch   | out | status, result_addr         | valid & ready
//
// One request at a time; the single-port heap RAM (one read or write per cycle)
// sets the pace. Allocate walks the free list link by link, then splits, grows
// the heap and coalesces as needed; release links the block in and coalesces.
// Reset and reinitialize sweep the whole RAM with zeros, then rebuild the
// prologue, epilogue and first chunk.
// The result sits in an output register; a stalled rsp_ch holds it, and the
// next request is taken once the sequencer is back in idle.
`default_nettype none
module explicit_free_list_allocator_core import efla_pkg::*; #(
   parameter int unsigned HEAP_BYTES  = DEF_HEAP_BYTES,
   parameter int unsigned CHUNK_BYTES = DEF_CHUNK_BYTES
) (
   input wire logic clock,
   input wire logic reset,
   efla_req_if.sink   req_ch,
   efla_rsp_if.source rsp_ch
);
   localparam int unsigned WORDS    = HEAP_BYTES / 4;
   localparam int          WA       = $clog2(WORDS);
   localparam int          TOP_W    = $clog2(HEAP_BYTES) + 1;
   localparam int unsigned LINK_MAX = HEAP_BYTES / 8;
   localparam int          CNT_W    = $clog2(LINK_MAX + 1);
   localparam logic [WORD_W-1:0] HEAP32  = WORD_W'(HEAP_BYTES);
   localparam logic [WORD_W-1:0] CHUNK32 = WORD_W'(CHUNK_BYTES);

   function automatic logic [WORD_W-1:0] grow_bytes(input logic [WORD_W-1:0] ext);
      grow_bytes = (((ext >> 2) + 32'd1) & ~32'd1) << 2;
   endfunction

   state_type state_ff, state_in;
   state_type ret_list_ff, ret_list_in, ret_merge_ff, ret_merge_in;
   state_type ret_grow_ff, ret_grow_in;

   logic [WORD_W-1:0] cbp_ff, cbp_in, head_ff, head_in, lbp_ff, lbp_in, lt_ff, lt_in;
   logic [WORD_W-1:0] mbp_ff, mbp_in, pv_ff, pv_in, nx_ff, nx_in, nsz_ff, nsz_in;
   logic [WORD_W-1:0] msz_ff, msz_in, csz_ff, csz_in, gbp_ff, gbp_in, gsz_ff, gsz_in;
   logic [WORD_W-1:0] gres_ff, gres_in;
   logic [SIZE_W:0]   asz_ff, asz_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WA-1:0]     clr_ff, clr_in;
   logic [TOP_W-1:0]  top_ff, top_in;
   logic              pa_ff, pa_in, na_ff, na_in, init_rsp_ff, init_rsp_in;
   status_type        st_ff, st_in;
   logic [ADDR_W-1:0] res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_addr_ff, rsp_addr_in;

   logic              mem_we;
   logic [WORD_W-1:0] mem_byte, mem_wdata, rdata, qs;
   logic [WA-1:0]     mem_addr;
   logic              req_acc, rsp_load;
   logic [WORD_W-1:0] top32, asz32, ext32, dsz;
   logic              split;

   assign qs      = rdata & SIZE_MASK;
   assign top32   = WORD_W'(top_ff);
   assign asz32   = WORD_W'(asz_ff);
   assign ext32   = (asz32 > CHUNK32) ? asz32 : CHUNK32;
   assign dsz     = csz_ff - asz32;
   assign split   = ((qs - asz32) >= MIN_BLOCK) && (qs >= asz32);
   assign req_acc = req_ch.valid && req_ch.ready;
   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ch.ready);
   assign mem_addr = (state_ff == S_CLEAR) ? clr_ff : mem_byte[WA+1:2];

   assign req_ch.ready       = (state_ff == S_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.result_addr = rsp_addr_ff;

   efla_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_heap (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (rdata)
   );

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               case (req_ch.kind)
                  KIND_ALLOC: state_in = (req_ch.req_size == '0) ? S_DONE : S_FF1;
                  KIND_FREE:  state_in = (req_ch.block_addr == '0) ? S_DONE : S_Q0;
                  KIND_INIT:  state_in = S_CLEAR;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_CLEAR:     state_in = (clr_ff == '1) ? S_INIT0 : S_CLEAR;
         S_INIT0:     state_in = S_INIT1;
         S_INIT1:     state_in = S_INIT2;
         S_INIT2:     state_in = S_G0;
         S_INIT3:     state_in = init_rsp_ff ? S_DONE : S_IDLE;
         S_FF1:       state_in = (cbp_ff == '0) ? S_AGROW : S_FF2;
         S_FF2:       state_in = (!rdata[0] && asz32 <= qs) ? S_T0 : S_FF3;
         S_FF3:       state_in = (cnt_ff == CNT_W'(LINK_MAX)) ? S_AGROW : S_FF1;
         S_AGROW:     state_in = S_G0;
         S_AGROW_RET: state_in = (gres_ff == '0) ? S_DONE : S_T0;
         S_T0:        state_in = S_T1;
         S_T1:        state_in = split ? S_T2 : S_TN1;
         S_T2:        state_in = S_T3;
         S_T3:        state_in = S_LR0;
         S_T4:        state_in = S_T5;
         S_T5:        state_in = S_T6;
         S_T6:        state_in = S_T7;
         S_T7:        state_in = S_LA0;
         S_TN1:       state_in = S_TN2;
         S_TN2:       state_in = S_LR0;
         S_AEND:      state_in = S_DONE;
         S_Q0:        state_in = S_Q1;
         S_Q1:        state_in = S_Q2;
         S_Q2:        state_in = S_Q3;
         S_Q3:        state_in = S_LA0;
         S_Q4:        state_in = S_M0;
         S_QEND:      state_in = S_DONE;
         S_G0:        state_in = ((HEAP32 - top32) < gsz_ff) ? ret_grow_ff : S_G1;
         S_G1:        state_in = S_G2;
         S_G2:        state_in = S_G3;
         S_G3:        state_in = S_LA0;
         S_G4:        state_in = S_M0;
         S_G5:        state_in = ret_grow_ff;
         S_M0:        state_in = S_M1;
         S_M1:        state_in = S_M2;
         S_M2:        state_in = S_M3;
         S_M3:        state_in = S_M4;
         S_M4:        state_in = S_M5;
         S_M5:        state_in = S_M6;
         S_M6: begin
            if (pa_ff && na_ff) begin
               state_in = ret_merge_ff;
            end else if (pa_ff) begin
               state_in = S_B1;
            end else if (na_ff) begin
               state_in = S_C1;
            end else begin
               state_in = S_D1;
            end
         end
         S_B1:        state_in = S_LR0;
         S_B2:        state_in = S_B3;
         S_B3:        state_in = ret_merge_ff;
         S_C1:        state_in = S_LR0;
         S_C2:        state_in = S_C3;
         S_C3:        state_in = S_C4;
         S_C4:        state_in = S_C5;
         S_C5:        state_in = S_C6;
         S_C6:        state_in = S_C7;
         S_C7:        state_in = S_C8;
         S_C8:        state_in = S_C9;
         S_C9:        state_in = ret_merge_ff;
         S_D1:        state_in = S_LR0;
         S_D2:        state_in = S_D3;
         S_D3:        state_in = S_LR0;
         S_D4:        state_in = S_D5;
         S_D5:        state_in = S_D6;
         S_D6:        state_in = S_D7;
         S_D7:        state_in = S_D8;
         S_D8:        state_in = S_D9;
         S_D9:        state_in = S_D10;
         S_D10:       state_in = S_D11;
         S_D11:       state_in = S_D12;
         S_D12:       state_in = S_D13;
         S_D13:       state_in = S_D14;
         S_D14:       state_in = ret_merge_ff;
         S_LA0:       state_in = S_LA1;
         S_LA1:       state_in = S_LA2;
         S_LA2:       state_in = ret_list_ff;
         S_LR0:       state_in = S_LR1;
         S_LR1:       state_in = (rdata != '0) ? S_LR2 : S_LR3;
         S_LR2:       state_in = S_LR3;
         S_LR3:       state_in = S_LR4;
         S_LR4:       state_in = (rdata != '0) ? S_LR5 : S_LR6;
         S_LR5:       state_in = S_LR6;
         S_LR6:       state_in = (lbp_ff == head_ff) ? S_LR7 : ret_list_ff;
         S_LR7:       state_in = ret_list_ff;
         S_DONE:      state_in = rsp_load ? S_IDLE : S_DONE;
         default:     state_in = S_IDLE;
      endcase
   end

   always_comb begin
      mem_we = 1'b0;
      mem_byte = '0;
      mem_wdata = '0;
      ret_list_in = ret_list_ff;
      ret_merge_in = ret_merge_ff;
      ret_grow_in = ret_grow_ff;
      cbp_in = cbp_ff;
      head_in = head_ff;
      lbp_in = lbp_ff;
      lt_in = lt_ff;
      mbp_in = mbp_ff;
      pv_in = pv_ff;
      nx_in = nx_ff;
      nsz_in = nsz_ff;
      msz_in = msz_ff;
      csz_in = csz_ff;
      gbp_in = gbp_ff;
      gsz_in = gsz_ff;
      gres_in = gres_ff;
      asz_in = asz_ff;
      cnt_in = cnt_ff;
      clr_in = clr_ff;
      top_in = top_ff;
      pa_in = pa_ff;
      na_in = na_ff;
      init_rsp_in = init_rsp_ff;
      st_in = st_ff;
      res_in = res_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               st_in = STATUS_NULL;
               res_in = '0;
               cnt_in = '0;
               clr_in = '0;
               cbp_in = (req_ch.kind == KIND_FREE) ? WORD_W'(req_ch.block_addr) : head_ff;
               if (req_ch.req_size <= 16'd8) begin
                  asz_in = (SIZE_W+1)'(MIN_BLOCK);
               end else begin
                  asz_in = ((SIZE_W+1)'(req_ch.req_size) + 17'd15) & ~17'd7;
               end
               if (req_ch.kind == KIND_INIT) begin
                  init_rsp_in = 1'b1;
                  head_in = '0;
               end
            end
         end
         S_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + 1'b1;
         end
         S_INIT0: begin
            mem_we = 1'b1;
            mem_byte = 32'd4;
            mem_wdata = PROLOGUE_WORD;
         end
         S_INIT1: begin
            mem_we = 1'b1;
            mem_byte = 32'd8;
            mem_wdata = PROLOGUE_WORD;
         end
         S_INIT2: begin
            mem_we = 1'b1;
            mem_byte = 32'd12;
            mem_wdata = EPILOGUE_WORD;
            top_in = TOP_W'(FIRST_BP);
            gsz_in = grow_bytes(CHUNK32);
            ret_grow_in = S_INIT3;
         end
         S_INIT3: st_in = (gres_ff != '0) ? STATUS_OK : STATUS_OOM;
         S_FF1: mem_byte = cbp_ff - 32'd4;
         S_FF2: mem_byte = cbp_ff;
         S_FF3: begin
            cbp_in = rdata;
            cnt_in = cnt_ff + 1'b1;
         end
         S_AGROW: begin
            gsz_in = grow_bytes(ext32);
            ret_grow_in = S_AGROW_RET;
         end
         S_AGROW_RET: begin
            cbp_in = gres_ff;
            if (gres_ff == '0) begin
               st_in = STATUS_OOM;
            end
         end
         S_T0: mem_byte = cbp_ff - 32'd4;
         S_T1: begin
            csz_in = qs;
            mem_we = 1'b1;
            mem_byte = cbp_ff - 32'd4;
            mem_wdata = split ? (asz32 | ALLOC_BIT) : (qs | ALLOC_BIT);
         end
         S_T2: begin
            mem_we = 1'b1;
            mem_byte = cbp_ff + asz32 - 32'd8;
            mem_wdata = asz32 | ALLOC_BIT;
         end
         S_T3: begin
            lbp_in = cbp_ff;
            ret_list_in = S_T4;
         end
         S_T4: mem_byte = cbp_ff - 32'd4;
         S_T5: begin
            lbp_in = cbp_ff + qs;
            mem_we = 1'b1;
            mem_byte = cbp_ff + qs - 32'd4;
            mem_wdata = dsz;
         end
         S_T6: begin
            mem_we = 1'b1;
            mem_byte = lbp_ff + dsz - 32'd8;
            mem_wdata = dsz;
         end
         S_T7: ret_list_in = S_AEND;
         S_TN1: begin
            mem_we = 1'b1;
            mem_byte = cbp_ff + csz_ff - 32'd8;
            mem_wdata = csz_ff | ALLOC_BIT;
         end
         S_TN2: begin
            lbp_in = cbp_ff;
            ret_list_in = S_AEND;
         end
         S_AEND: begin
            st_in = STATUS_OK;
            res_in = cbp_ff[ADDR_W-1:0];
         end
         S_Q0: mem_byte = cbp_ff - 32'd4;
         S_Q1: begin
            csz_in = qs;
            mem_we = 1'b1;
            mem_byte = cbp_ff - 32'd4;
            mem_wdata = qs;
         end
         S_Q2: begin
            mem_we = 1'b1;
            mem_byte = cbp_ff + csz_ff - 32'd8;
            mem_wdata = csz_ff;
         end
         S_Q3: begin
            lbp_in = cbp_ff;
            ret_list_in = S_Q4;
         end
         S_Q4: begin
            mbp_in = cbp_ff;
            ret_merge_in = S_QEND;
         end
         S_QEND: st_in = STATUS_OK;
         S_G0: begin
            if ((HEAP32 - top32) < gsz_ff) begin
               gres_in = '0;
            end else begin
               gbp_in = top32;
               top_in = top_ff + TOP_W'(gsz_ff);
               mem_we = 1'b1;
               mem_byte = top32 - 32'd4;
               mem_wdata = gsz_ff;
            end
         end
         S_G1: begin
            mem_we = 1'b1;
            mem_byte = gbp_ff + gsz_ff - 32'd8;
            mem_wdata = gsz_ff;
         end
         S_G2: begin
            mem_we = 1'b1;
            mem_byte = gbp_ff + gsz_ff - 32'd4;
            mem_wdata = EPILOGUE_WORD;
         end
         S_G3: begin
            lbp_in = gbp_ff;
            ret_list_in = S_G4;
         end
         S_G4: begin
            mbp_in = gbp_ff;
            ret_merge_in = S_G5;
         end
         S_G5: gres_in = mbp_ff;
         S_M0: mem_byte = mbp_ff - 32'd8;
         S_M1: begin
            pv_in = mbp_ff - qs;
            mem_byte = mbp_ff - qs - 32'd4;
         end
         S_M2: mem_byte = pv_ff + qs - 32'd8;
         S_M3: begin
            pa_in = rdata[0];
            mem_byte = mbp_ff - 32'd4;
         end
         S_M4: begin
            nx_in = mbp_ff + qs;
            mem_byte = mbp_ff + qs - 32'd4;
         end
         S_M5: begin
            na_in = rdata[0];
            nsz_in = qs;
            mem_byte = mbp_ff - 32'd4;
         end
         S_M6: msz_in = (pa_ff && !na_ff) ? qs + nsz_ff : qs;
         S_B1: begin
            lbp_in = nx_ff;
            ret_list_in = S_B2;
         end
         S_B2: begin
            mem_we = 1'b1;
            mem_byte = mbp_ff - 32'd4;
            mem_wdata = msz_ff;
         end
         S_B3: begin
            mem_we = 1'b1;
            mem_byte = mbp_ff + msz_ff - 32'd8;
            mem_wdata = msz_ff;
         end
         S_C1, S_D1: begin
            lbp_in = mbp_ff;
            ret_list_in = (state_ff == S_C1) ? S_C2 : S_D2;
         end
         S_C2, S_C6, S_C8, S_D4, S_D13: mem_byte = mbp_ff - 32'd8;
         S_D8: begin
            msz_in = msz_ff + qs;
            mem_byte = mbp_ff - 32'd8;
         end
         S_C3, S_D5: mem_byte = mbp_ff - qs - 32'd4;
         S_C4, S_D6: begin
            msz_in = msz_ff + qs;
            mem_byte = mbp_ff - 32'd4;
         end
         S_C5: begin
            mem_we = 1'b1;
            mem_byte = mbp_ff + qs - 32'd8;
            mem_wdata = msz_ff;
         end
         S_C7, S_D9: begin
            mem_we = 1'b1;
            mem_byte = mbp_ff - qs - 32'd4;
            mem_wdata = msz_ff;
         end
         S_C9, S_D14: mbp_in = mbp_ff - qs;
         S_D2, S_D10: mem_byte = mbp_ff - 32'd4;
         S_D3: begin
            lbp_in = mbp_ff + qs;
            ret_list_in = S_D4;
         end
         S_D7: mem_byte = mbp_ff + qs - 32'd4;
         S_D11: begin
            nx_in = mbp_ff + qs;
            mem_byte = mbp_ff + qs - 32'd4;
         end
         S_D12: begin
            mem_we = 1'b1;
            mem_byte = nx_ff + qs - 32'd8;
            mem_wdata = msz_ff;
         end
         S_LA0: begin
            mem_we = 1'b1;
            mem_byte = lbp_ff;
            mem_wdata = head_ff;
         end
         S_LA1: begin
            mem_we = 1'b1;
            mem_byte = lbp_ff + 32'd8;
            mem_wdata = '0;
         end
         S_LA2: begin
            mem_we = (head_ff != '0);
            mem_byte = head_ff + 32'd8;
            mem_wdata = lbp_ff;
            head_in = lbp_ff;
         end
         S_LR0: mem_byte = lbp_ff;
         S_LR1: begin
            lt_in = rdata;
            mem_byte = lbp_ff + 32'd8;
         end
         S_LR2: begin
            mem_we = 1'b1;
            mem_byte = lt_ff + 32'd8;
            mem_wdata = rdata;
         end
         S_LR3: mem_byte = lbp_ff + 32'd8;
         S_LR4: begin
            lt_in = rdata;
            mem_byte = lbp_ff;
         end
         S_LR5: begin
            mem_we = 1'b1;
            mem_byte = lt_ff;
            mem_wdata = rdata;
         end
         S_LR6: mem_byte = head_ff;
         S_LR7: head_in = rdata;
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in = rsp_addr_ff;
      if (rsp_ch.valid && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_status_in = st_ff;
         rsp_addr_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         head_ff <= '0;
         top_ff <= TOP_W'(FIRST_BP);
         init_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ret_list_ff <= S_IDLE;
         ret_merge_ff <= S_IDLE;
         ret_grow_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         head_ff <= head_in;
         top_ff <= top_in;
         init_rsp_ff <= init_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
         ret_list_ff <= ret_list_in;
         ret_merge_ff <= ret_merge_in;
         ret_grow_ff <= ret_grow_in;
      end
   end

   always_ff @(posedge clock) begin
      cbp_ff <= cbp_in;
      lbp_ff <= lbp_in;
      lt_ff <= lt_in;
      mbp_ff <= mbp_in;
      pv_ff <= pv_in;
      nx_ff <= nx_in;
      nsz_ff <= nsz_in;
      msz_ff <= msz_in;
      csz_ff <= csz_in;
      gbp_ff <= gbp_in;
      gsz_ff <= gsz_in;
      gres_ff <= gres_in;
      asz_ff <= asz_in;
      cnt_ff <= cnt_in;
      pa_ff <= pa_in;
      na_ff <= na_in;
      st_ff <= st_in;
      res_ff <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff <= rsp_addr_in;
   end

   a_top_bound: assert property (@(posedge clock) disable iff (reset)
      WORD_W'(top_ff) <= HEAP32)
      else $error("heap top beyond heap");

   a_top_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff != S_INIT2 |=> top_ff >= $past(top_ff))
      else $error("heap top shrank outside rebuild");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !mem_we)
      else $error("heap write while idle");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("response raised outside done");

endmodule
`default_nettype wire

/* rtl/efla_ram.sv */
`default_nettype none
module efla_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

/* sim/tb_explicit_free_list_allocator_core.sv */
`timescale 1ns / 100ps
`default_nettype none
module tb_explicit_free_list_allocator_core;
   import efla_pkg::*;

   localparam int unsigned HEAP_W = DEF_HEAP_BYTES / 4;
   localparam int N_RANDOM = 400;
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

   typedef struct packed {
      status_type      status;
      logic [ADDR_W-1:0] addr;
   } heap_result_type;

   class heap_scoreboard;
      logic [31:0]  mem [HEAP_W];
      logic [31:0]  head;
      logic [31:0]  top;
      heap_result_type pending [$];
      int unsigned  live [$];
      int           errors;
      int           n_alloc, n_free, n_oom, n_null, n_init, n_checked;

      function logic [31:0] rd(logic [31:0] a);
         return mem[(a >> 2) % HEAP_W];
      endfunction

      function void wr(logic [31:0] a, logic [31:0] v);
         mem[(a >> 2) % HEAP_W] = v;
      endfunction

      function logic [31:0] bsize(logic [31:0] bp);
         return rd(bp - 4) & SIZE_MASK;
      endfunction

      function logic [31:0] bfoot(logic [31:0] bp);
         return bp + bsize(bp) - 8;
      endfunction

      function logic [31:0] bnext(logic [31:0] bp);
         return bp + bsize(bp);
      endfunction

      function logic [31:0] bprev(logic [31:0] bp);
         return bp - (rd(bp - 8) & SIZE_MASK);
      endfunction

      function void link_in(logic [31:0] bp);
         wr(bp, head);
         wr(bp + 8, 0);
         if (head != 0) wr(head + 8, bp);
         head = bp;
      endfunction

      function void unlink(logic [31:0] bp);
         logic [31:0] nx, pv;
         nx = rd(bp);
         if (nx != 0) wr(nx + 8, rd(bp + 8));
         pv = rd(bp + 8);
         if (pv != 0) wr(pv, rd(bp));
         if (bp == head) head = rd(head);
      endfunction

      function logic [31:0] coalesce(logic [31:0] bp);
         logic [31:0] pa, na, sz;
         pa = rd(bfoot(bprev(bp))) & ALLOC_BIT;
         na = rd(bnext(bp) - 4) & ALLOC_BIT;
         sz = bsize(bp);
         if (pa != 0 && na != 0) return bp;
         if (pa != 0) begin
            sz += bsize(bnext(bp));
            unlink(bnext(bp));
            wr(bp - 4, sz);
            wr(bfoot(bp), sz);
         end else if (na != 0) begin
            unlink(bp);
            sz += bsize(bprev(bp));
            wr(bfoot(bp), sz);
            wr(bprev(bp) - 4, sz);
            bp = bprev(bp);
         end else begin
            unlink(bp);
            unlink(bnext(bp));
            sz += bsize(bprev(bp)) + bsize(bnext(bp));
            wr(bprev(bp) - 4, sz);
            wr(bfoot(bnext(bp)), sz);
            bp = bprev(bp);
         end
         return bp;
      endfunction

      function logic [31:0] extend(logic [31:0] words);
         logic [31:0] sz, bp;
         sz = ((words + 1) & ~32'd1) * 4;
         bp = top;
         if (DEF_HEAP_BYTES - top < sz) return 0;
         top += sz;
         wr(bp - 4, sz);
         wr(bp + sz - 8, sz);
         wr(bp + sz - 4, ALLOC_BIT);
         link_in(bp);
         return coalesce(bp);
      endfunction

      function void carve(logic [31:0] bp, logic [31:0] asz);
         logic [31:0] csz;
         csz = bsize(bp);
         if (csz - asz >= MIN_BLOCK && csz >= asz) begin
            wr(bp - 4, asz | ALLOC_BIT);
            wr(bfoot(bp), asz | ALLOC_BIT);
            unlink(bp);
            bp = bnext(bp);
            wr(bp - 4, csz - asz);
            wr(bfoot(bp), csz - asz);
            link_in(bp);
         end else begin
            wr(bp - 4, csz | ALLOC_BIT);
            wr(bfoot(bp), csz | ALLOC_BIT);
            unlink(bp);
         end
      endfunction

      function logic [31:0] scan_list(logic [31:0] asz);
         logic [31:0] bp;
         bp = head;
         for (int n = 0; n <= DEF_HEAP_BYTES / 8 && bp != 0; n++) begin
            if ((rd(bp - 4) & ALLOC_BIT) == 0 && asz <= bsize(bp)) return bp;
            bp = rd(bp);
         end
         return 0;
      endfunction

      function bit rebuild();
         foreach (mem[i]) mem[i] = 0;
         head = 0;
         wr(4, PROLOGUE_WORD);
         wr(8, PROLOGUE_WORD);
         wr(12, EPILOGUE_WORD);
         top = FIRST_BP;
         live.delete();
         return extend(DEF_CHUNK_BYTES / 4) != 0;
      endfunction

      function void note(logic [KIND_W-1:0] kind, logic [SIZE_W-1:0] sz,
                         logic [ADDR_W-1:0] addr);
         heap_result_type r;
         logic [31:0] asz, bp, ext;
         r.status = STATUS_NULL;
         r.addr = '0;
         if (kind == KIND_ALLOC) begin
            if (sz != 0) begin
               asz = (sz <= 8) ? MIN_BLOCK : 8 * ((32'(sz) + 15) / 8);
               bp = scan_list(asz);
               if (bp == 0) begin
                  ext = (asz > DEF_CHUNK_BYTES) ? asz : DEF_CHUNK_BYTES;
                  bp = extend(ext / 4);
               end
               if (bp == 0) begin
                  r.status = STATUS_OOM;
                  n_oom++;
               end else begin
                  carve(bp, asz);
                  r.status = STATUS_OK;
                  r.addr = bp[ADDR_W-1:0];
                  live.push_back(bp);
                  n_alloc++;
               end
            end else n_null++;
         end else if (kind == KIND_FREE) begin
            if (addr != 0) begin
               asz = bsize(addr);
               wr(addr - 4, asz);
               wr(bfoot(addr), asz);
               link_in(addr);
               void'(coalesce(addr));
               r.status = STATUS_OK;
               foreach (live[i]) if (live[i] == addr) begin
                  live.delete(i);
                  break;
               end
               n_free++;
            end else n_null++;
         end else if (kind == KIND_INIT) begin
            r.status = rebuild() ? STATUS_OK : STATUS_OOM;
            n_init++;
         end else n_null++;
         pending.push_back(r);
      endfunction

      function void check(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] addr);
         heap_result_type e;
         n_checked++;
         if (pending.size() == 0) begin
            $error("unexpected response: status %0d result_addr %0d", status, addr);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status);
            errors++;
         end
         if (addr !== e.addr) begin
            $error("result_addr: expected %0d, got %0d", e.addr, addr);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   efla_req_if req_ch ();
   efla_rsp_if rsp_ch ();
   heap_scoreboard sb;
   bit quiet;

   explicit_free_list_allocator_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send(logic [KIND_W-1:0] kind, logic [SIZE_W-1:0] sz,
                       logic [ADDR_W-1:0] addr);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.kind       <= kind;
      req_ch.req_size   <= sz;
      req_ch.block_addr <= addr;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note(kind, sz, addr);
   endtask

   task automatic free_live();
      int i;
      logic [31:0] bp;
      i = $urandom_range(0, sb.live.size() - 1);
      bp = sb.live[i];
      send(KIND_FREE, '0, bp[ADDR_W-1:0]);
   endtask

   task automatic random_item();
      int r;
      r = $urandom_range(0, 199);
      if (r < 2) send(KIND_INIT, SIZE_W'($urandom), ADDR_W'($urandom));
      else if (r < 5) send(KIND_NONE, SIZE_W'($urandom), ADDR_W'($urandom));
      else if (r < 9) send(KIND_FREE, SIZE_W'($urandom), ADDR_W'($urandom));
      else if (r < 11) send(KIND_ALLOC, '0, ADDR_W'($urandom));
      else if (r < 13) send(KIND_FREE, SIZE_W'($urandom), '0);
      else if (r < 100 && sb.live.size() > 0) free_live();
      else if (r < 180) send(KIND_ALLOC, SIZE_W'($urandom_range(1, 128)), ADDR_W'($urandom));
      else if (r < 197) send(KIND_ALLOC, SIZE_W'($urandom_range(129, 2048)),
                             ADDR_W'($urandom));
      else send(KIND_ALLOC, SIZE_W'($urandom_range(2049, 65535)), ADDR_W'($urandom));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check(rsp_ch.status, rsp_ch.result_addr);
   end

   initial begin
      int g;
      forever begin
         g = pick_gap();
         if (g > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   initial begin
      #400_000_000;
      $display("tb_explicit_free_list_allocator_core failed");
      $finish;
   end

   initial begin
      logic [31:0] a, b, c, d;
      int waited;
      sb = new();
      void'(sb.rebuild());
      reset             <= 1'b1;
      req_ch.valid      <= 1'b0;
      req_ch.kind       <= KIND_ALLOC;
      req_ch.req_size   <= '0;
      req_ch.block_addr <= '0;
      quiet = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // zero size, null release, unused kind, rounding edges, heap full
      send(KIND_ALLOC, '0, 16'hFFFF);
      send(KIND_FREE, 16'hFFFF, '0);
      send(KIND_NONE, 16'hFFFF, 16'hFFFF);
      send(KIND_ALLOC, 16'd1, '0);
      send(KIND_ALLOC, 16'd8, '0);
      send(KIND_ALLOC, 16'd9, '0);
      send(KIND_ALLOC, 16'd16, '0);
      send(KIND_ALLOC, 16'hFFFF, '0);
      // coalescing on adjacent blocks: both neighbours allocated, then both free
      send(KIND_ALLOC, 16'd40, '0); a = sb.live[sb.live.size()-1];
      send(KIND_ALLOC, 16'd40, '0); b = sb.live[sb.live.size()-1];
      send(KIND_ALLOC, 16'd40, '0); c = sb.live[sb.live.size()-1];
      send(KIND_ALLOC, 16'd40, '0); d = sb.live[sb.live.size()-1];
      send(KIND_FREE, '0, a[15:0]);
      send(KIND_FREE, '0, c[15:0]);
      send(KIND_FREE, '0, b[15:0]);
      send(KIND_FREE, '0, d[15:0]);
      send(KIND_ALLOC, 16'd300, '0);
      send(KIND_ALLOC, 16'd5000, '0);
      send(KIND_FREE, '0, 16'hFFFF);
      send(KIND_INIT, '0, '0);
      send(KIND_ALLOC, 16'd200, '0);

      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 100 == 50) quiet = 1'b1;
         if (i % 100 == 80) quiet = 1'b0;
         random_item();
      end
      req_ch.valid <= 1'b0;

      waited = 0;
      while (sb.pending.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      $display("covered %0d allocations, %0d releases, %0d out-of-memory, %0d null, %0d reinits",
               sb.n_alloc, sb.n_free, sb.n_oom, sb.n_null, sb.n_init);
      $display("%0d responses checked, %0d mismatches", sb.n_checked, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("tb_explicit_free_list_allocator_core passed");
      end else begin
         if (sb.pending.size() != 0) $error("%0d responses missing", sb.pending.size());
         $display("tb_explicit_free_list_allocator_core failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
